[sv/msc_pkg.sv]
// Shared types, widths, constants and helpers for the magnetometer calibration unit.
// Used by every module of the block; depends on nothing.
package msc_pkg;

  localparam int RAW_W     = 16;
  localparam int SENS_W    = 16;
  localparam int HI_W      = 24;
  localparam int ROW_W     = 48;
  localparam int COEF_W    = 16;
  localparam int M_W       = 34;
  localparam int PROD_W    = M_W + COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_SH   = 14;
  localparam int Q_W       = ACC_W + 1 - FRAC_SH;
  localparam int FIELD_W   = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES  = 3;

  localparam logic signed [RAW_W-1:0] OVF_LIMIT = -16'sd2048;
  localparam logic [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(8192);

  localparam logic [SENS_W-1:0] SENS_RESET  = 16'd4096;
  localparam logic [HI_W-1:0]   HI_RESET    = 24'd0;
  localparam logic [ROW_W-1:0]  ROW_X_RESET = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0]  ROW_Y_RESET = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0]  ROW_Z_RESET = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS   = 3'd0,
    CFG_HI_X   = 3'd1,
    CFG_HI_Y   = 3'd2,
    CFG_HI_Z   = 3'd3,
    CFG_ROW_X  = 3'd4,
    CFG_ROW_Y  = 3'd5,
    CFG_ROW_Z  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORR,
    ST_CALC,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_first;
    logic signed [RAW_W-1:0] raw_second;
    logic signed [RAW_W-1:0] raw_third;
  } in_word_t;

  typedef struct packed {
    logic                      status;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic [CNT_W-1:0]          sample_number;
  } out_word_t;

  typedef logic signed [M_W-1:0] m_val_t;
  typedef m_val_t [NUM_AXES-1:0] m_vec_t;

  typedef struct packed {
    logic                      done;
    logic signed [FIELD_W-1:0] value;
  } lane_res_t;

  function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W:0]          t;
    logic signed [Q_W-1:0]   q;
    logic [Q_W-FIELD_W:0]    top_bits;
    logic signed [FIELD_W-1:0] res;
    t = {acc[ACC_W-1], acc} + ROUND_HALF;
    q = $signed(t[ACC_W:FRAC_SH]);
    top_bits = q[Q_W-1:FIELD_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      res = q[FIELD_W-1:0];
    end else if (q[Q_W-1]) begin
      res = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[sv/msc_axis_lane.sv]
// One axis correction lane: sign remap, sensitivity scale and hard-iron offset.
// Depends on msc_pkg for widths.
module msc_axis_lane (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 negate,
  input  logic signed [msc_pkg::RAW_W-1:0]     raw,
  input  logic [msc_pkg::SENS_W-1:0]           sens,
  input  logic [msc_pkg::HI_W-1:0]             offset,
  output msc_pkg::m_val_t                      m
);

  logic signed [msc_pkg::RAW_W:0]       axis_v;
  logic signed [msc_pkg::SENS_W:0]      sens_v;
  logic signed [msc_pkg::M_W-1:0]       prod;
  logic signed [msc_pkg::M_W-1:0]       off_v;
  msc_pkg::m_val_t                      m_r;
  msc_pkg::m_val_t                      m_nxt;

  always_comb begin
    axis_v = negate ? -$signed({raw[msc_pkg::RAW_W-1], raw}) : $signed({raw[msc_pkg::RAW_W-1], raw});
    sens_v = $signed({1'b0, sens});
    prod   = axis_v * sens_v;
    off_v  = $signed({{(msc_pkg::M_W - msc_pkg::HI_W){offset[msc_pkg::HI_W-1]}}, offset});
    m_nxt  = prod - off_v;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_r <= m_nxt;
    end
  end

  assign m = m_r;

endmodule

[sv/msc_row_lane.sv]
// One soft-iron row lane: multiply-accumulate over three axes, then round and saturate.
// Depends on msc_pkg for widths, lane result type and round_sat.
module msc_row_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  msc_pkg::m_vec_t             m,
  input  logic [msc_pkg::ROW_W-1:0]   row,
  output msc_pkg::lane_res_t          res
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic [2:0]                          step_r;
  logic                                busy_r;
  logic                                done_r;
  logic signed [msc_pkg::PROD_W-1:0]   prod_r;
  logic signed [msc_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [msc_pkg::ACC_W-1:0]    acc_r;
  logic signed [msc_pkg::FIELD_W-1:0]  value_r;
  logic signed [msc_pkg::M_W-1:0]      m_sel;
  logic signed [msc_pkg::COEF_W-1:0]   coef_sel;

  always_comb begin
    unique case (step_r[1:0])
      2'd0: begin
        m_sel    = $signed(m[0]);
        coef_sel = $signed(row[msc_pkg::COEF_W-1:0]);
      end
      2'd1: begin
        m_sel    = $signed(m[1]);
        coef_sel = $signed(row[2*msc_pkg::COEF_W-1:msc_pkg::COEF_W]);
      end
      2'd2: begin
        m_sel    = $signed(m[2]);
        coef_sel = $signed(row[3*msc_pkg::COEF_W-1:2*msc_pkg::COEF_W]);
      end
      default: begin
        m_sel    = '0;
        coef_sel = '0;
      end
    endcase
    if (step_r[2]) begin
      prod_nxt = '0;
    end else begin
      prod_nxt = m_sel * coef_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_r + msc_pkg::ACC_W'(prod_r);
      if (step_r == LAST_STEP) begin
        value_r <= msc_pkg::round_sat(acc_r);
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = value_r;

endmodule

[sv/msc_merge.sv]
// Merging stage: joins the three row results, status and sample count into the output word.
// Depends on msc_pkg for the output word and lane result types.
module msc_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 ovf,
  input  msc_pkg::lane_res_t   res_x,
  input  msc_pkg::lane_res_t   res_y,
  input  msc_pkg::lane_res_t   res_z,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output msc_pkg::out_word_t   out_data
);

  logic                        valid_r;
  logic [msc_pkg::CNT_W-1:0]   count_r;
  logic [msc_pkg::CNT_W-1:0]   count_nxt;
  msc_pkg::out_word_t          data_r;
  msc_pkg::out_word_t          data_nxt;

  assign free      = !valid_r || !out_stall;
  assign count_nxt = count_r + msc_pkg::CNT_W'(1);

  always_comb begin
    if (ovf) begin
      data_nxt        = '0;
      data_nxt.status = 1'b1;
    end else begin
      data_nxt.status        = 1'b0;
      data_nxt.field_x       = res_x.value;
      data_nxt.field_y       = res_y.value;
      data_nxt.field_z       = res_z.value;
      data_nxt.sample_number = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
      if (load && !ovf) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + msc_pkg::CNT_W'(1)))
    else $error("sample counter moved by more than one");

  a_count_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (load && ovf) |=> count_r == $past(count_r))
    else $error("overflow word advanced the sample counter");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.status) |-> (data_r.field_x == '0 && data_r.field_y == '0 &&
                                    data_r.field_z == '0 && data_r.sample_number == '0))
    else $error("overflow word carries nonzero fields");

endmodule

[sv/magnetometer_sample_calibrate_unit.sv]
// Magnetometer calibration top level: config registers, sequencer, axis and row lanes, merge.
// Flow: a word is accepted only in idle; in_stall then holds off the next word through
// correction, the three-step multiply-accumulate in the row lanes, rounding and the
// output load, which itself waits while the output stage is stalled.
// Reset: synchronous active-low rst_n restores the register defaults and clears the count.
// Depends on msc_pkg, msc_axis_lane, msc_row_lane and msc_merge.
module magnetometer_sample_calibrate_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  msc_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output msc_pkg::out_word_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [msc_pkg::ROW_W-1:0]            cfg_data
);

  logic [msc_pkg::SENS_W-1:0]  sens_r;
  logic [msc_pkg::HI_W-1:0]    hi_x_r;
  logic [msc_pkg::HI_W-1:0]    hi_y_r;
  logic [msc_pkg::HI_W-1:0]    hi_z_r;
  logic [msc_pkg::ROW_W-1:0]   row_x_r;
  logic [msc_pkg::ROW_W-1:0]   row_y_r;
  logic [msc_pkg::ROW_W-1:0]   row_z_r;

  msc_pkg::state_e             state_r;
  msc_pkg::state_e             state_nxt;
  msc_pkg::in_word_t           raw_r;
  logic                        ovf_r;
  logic                        ovf_nxt;
  logic                        accept;
  logic                        load_m;
  logic                        start;
  logic                        load_out;
  logic                        out_free;

  msc_pkg::m_val_t             m_x;
  msc_pkg::m_val_t             m_y;
  msc_pkg::m_val_t             m_z;
  msc_pkg::m_vec_t             m_vec;
  msc_pkg::lane_res_t          res_x;
  msc_pkg::lane_res_t          res_y;
  msc_pkg::lane_res_t          res_z;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != msc_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;

  assign ovf_nxt = (in_data.raw_first < msc_pkg::OVF_LIMIT) ||
                   (in_data.raw_second < msc_pkg::OVF_LIMIT) ||
                   (in_data.raw_third < msc_pkg::OVF_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= msc_pkg::SENS_RESET;
      hi_x_r  <= msc_pkg::HI_RESET;
      hi_y_r  <= msc_pkg::HI_RESET;
      hi_z_r  <= msc_pkg::HI_RESET;
      row_x_r <= msc_pkg::ROW_X_RESET;
      row_y_r <= msc_pkg::ROW_Y_RESET;
      row_z_r <= msc_pkg::ROW_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msc_pkg::CFG_SENS:  sens_r  <= cfg_data[msc_pkg::SENS_W-1:0];
        msc_pkg::CFG_HI_X:  hi_x_r  <= cfg_data[msc_pkg::HI_W-1:0];
        msc_pkg::CFG_HI_Y:  hi_y_r  <= cfg_data[msc_pkg::HI_W-1:0];
        msc_pkg::CFG_HI_Z:  hi_z_r  <= cfg_data[msc_pkg::HI_W-1:0];
        msc_pkg::CFG_ROW_X: row_x_r <= cfg_data;
        msc_pkg::CFG_ROW_Y: row_y_r <= cfg_data;
        msc_pkg::CFG_ROW_Z: row_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= in_data;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_m    = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      msc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = msc_pkg::ST_CORR;
        end
      end
      msc_pkg::ST_CORR: begin
        load_m    = 1'b1;
        start     = 1'b1;
        state_nxt = msc_pkg::ST_CALC;
      end
      msc_pkg::ST_CALC: begin
        if (res_x.done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = msc_pkg::ST_IDLE;
          end else begin
            state_nxt = msc_pkg::ST_LOAD;
          end
        end
      end
      msc_pkg::ST_LOAD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = msc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msc_pkg::ST_IDLE;
    endcase
  end

  msc_axis_lane u_axis_x (
    .clk    (clk),
    .load   (load_m),
    .negate (1'b1),
    .raw    (raw_r.raw_first),
    .sens   (sens_r),
    .offset (hi_x_r),
    .m      (m_x)
  );

  msc_axis_lane u_axis_y (
    .clk    (clk),
    .load   (load_m),
    .negate (1'b0),
    .raw    (raw_r.raw_third),
    .sens   (sens_r),
    .offset (hi_y_r),
    .m      (m_y)
  );

  msc_axis_lane u_axis_z (
    .clk    (clk),
    .load   (load_m),
    .negate (1'b1),
    .raw    (raw_r.raw_second),
    .sens   (sens_r),
    .offset (hi_z_r),
    .m      (m_z)
  );

  assign m_vec[0] = m_x;
  assign m_vec[1] = m_y;
  assign m_vec[2] = m_z;

  msc_row_lane u_row_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .m     (m_vec),
    .row   (row_x_r),
    .res   (res_x)
  );

  msc_row_lane u_row_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .m     (m_vec),
    .row   (row_y_r),
    .res   (res_y)
  );

  msc_row_lane u_row_z (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .m     (m_vec),
    .row   (row_z_r),
    .res   (res_z)
  );

  msc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_out),
    .ovf       (ovf_r),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    (res_x.done == res_y.done) && (res_x.done == res_z.done))
    else $error("row lanes finished out of step");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    res_x.done |-> state_r == msc_pkg::ST_CALC)
    else $error("row lane finished outside the compute state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == msc_pkg::ST_CALC ||
                          $past(state_r) == msc_pkg::ST_LOAD))
    else $error("output word loaded without a finished computation");

endmodule
